>>> design/mdd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the median drop detector.
// No dependencies.
package mdd_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int SMP_W        = 16;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);

  typedef logic [SMP_W-1:0] smp_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam smp_t THR_RESET = smp_t'(640);

  // control from the sequencer to the cell row
  typedef struct packed {
    logic ins_en;    // insert the sample this cycle
    logic tap_load;  // copy the window into the read-out taps
    logic tap_shift; // move the taps one cell toward cell 0
  } ctl_t;

endpackage

>>> design/mdd_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted window: a stored sample plus a read-out tap.
// Depends on mdd_pkg.
module mdd_cell (
  input  logic          clk,
  input  mdd_pkg::ctl_t ctl,
  input  mdd_pkg::smp_t ins_val,
  input  logic          occ,
  input  logic          at_end,
  input  logic          left_gt,
  input  mdd_pkg::smp_t left_val,
  input  mdd_pkg::smp_t tap_in,
  output logic          gt,
  output mdd_pkg::smp_t val,
  output mdd_pkg::smp_t tap
);

  mdd_pkg::smp_t val_r, val_nxt;
  mdd_pkg::smp_t tap_r, tap_nxt;

  assign gt = occ && (val_r > ins_val);

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_en) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt || at_end) begin
        val_nxt = ins_val;
      end
    end
    tap_nxt = tap_r;
    if (ctl.tap_load) begin
      tap_nxt = val_nxt;
    end else if (ctl.tap_shift) begin
      tap_nxt = tap_in;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    tap_r <= tap_nxt;
  end

  assign val = val_r;
  assign tap = tap_r;

endmodule

>>> design/mdd_chain.sv
`timescale 1ns / 1ps
// Row of mdd_cell instances forming the sorted window and its read-out path.
// Depends on mdd_pkg and mdd_cell.
module mdd_chain (
  input  logic          clk,
  input  mdd_pkg::ctl_t ctl,
  input  mdd_pkg::smp_t ins_val,
  input  mdd_pkg::cnt_t count,
  output mdd_pkg::smp_t tap_head
);

  localparam int N = mdd_pkg::WINDOW_DEPTH;

  logic          gt   [N];
  mdd_pkg::smp_t val  [N];
  mdd_pkg::smp_t tap  [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic          occ_i, end_i, lgt_i;
    mdd_pkg::smp_t lval_i, tin_i;

    assign occ_i = count > mdd_pkg::cnt_t'(i);
    assign end_i = count == mdd_pkg::cnt_t'(i);

    if (i == 0) begin : g_first
      assign lgt_i  = 1'b0;
      assign lval_i = '0;
    end else begin : g_rest
      assign lgt_i  = gt[i-1];
      assign lval_i = val[i-1];
    end

    if (i == N - 1) begin : g_last
      assign tin_i = '0;
    end else begin : g_mid
      assign tin_i = tap[i+1];
    end

    mdd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .ins_val  (ins_val),
      .occ      (occ_i),
      .at_end   (end_i),
      .left_gt  (lgt_i),
      .left_val (lval_i),
      .tap_in   (tin_i),
      .gt       (gt[i]),
      .val      (val[i]),
      .tap      (tap[i])
    );
  end

  assign tap_head = tap[0];

endmodule

>>> design/median_drop_detector_core.sv
`timescale 1ns / 1ps
// Median drop detector top level: sequencer, flags and output register.
// Depends on mdd_pkg and mdd_chain.
//
//  channel | ports                                           | handshake
//  in      | in_sample, in_restart, in_clear_drop            | in_valid / in_stall
//  out     | out_window_median, out_trigger_armed,           | out_valid / out_stall
//          | out_drop_detected, out_window_full              |
//  cfg     | cfg_wr_data                                     | cfg_wr_en
//
// An item's median position is m = (count-1)/2 (at most 31), reached by
// shifting the read-out taps of the cell row down to cell 0.
// Insertion into the sorted row happens in the accept cycle unless the window is full.
// Reset clears count, previous median and trigger/drop flags and presets the threshold; window cells are not reset.
// A new item is accepted while a result waits on out_stall; that item
// then holds in its last cycle until the output register frees up.
module median_drop_detector_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mdd_pkg::smp_t        in_sample,
  input  logic                 in_restart,
  input  logic                 in_clear_drop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mdd_pkg::smp_t        out_window_median,
  output logic                 out_trigger_armed,
  output logic                 out_drop_detected,
  output logic                 out_window_full,
  input  logic                 cfg_wr_en,
  input  mdd_pkg::smp_t        cfg_wr_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t        state_r, state_nxt;
  mdd_pkg::cnt_t count_r, count_nxt;
  mdd_pkg::idx_t scan_r, scan_nxt;
  mdd_pkg::smp_t prev_r, prev_nxt;
  mdd_pkg::smp_t thr_r, thr_nxt;
  logic          trig_r, trig_nxt;
  logic          drop_r, drop_nxt;
  logic          full_r, full_nxt;
  logic          out_valid_r, out_valid_nxt;
  mdd_pkg::smp_t out_med_r, out_med_nxt;
  logic          out_trig_r, out_trig_nxt;
  logic          out_drop_r, out_drop_nxt;
  logic          out_full_r, out_full_nxt;

  logic          accept;
  mdd_pkg::cnt_t cnt_eff, cnt_new;
  mdd_pkg::idx_t med_idx;
  mdd_pkg::smp_t diff;
  logic          is_full, drop_clr;
  mdd_pkg::ctl_t ctl;
  mdd_pkg::smp_t tap_head;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign cnt_eff = in_restart ? '0 : count_r;
  assign is_full = (cnt_eff == mdd_pkg::cnt_t'(mdd_pkg::WINDOW_DEPTH));
  assign cnt_new = is_full ? cnt_eff : cnt_eff + 1'b1;
  assign med_idx = mdd_pkg::idx_t'((cnt_new - 1'b1) >> 1);
  assign diff    = (in_sample >= prev_r) ? in_sample - prev_r : prev_r - in_sample;
  assign drop_clr = in_clear_drop ? 1'b0 : drop_r;

  assign ctl.ins_en    = accept && !is_full;
  assign ctl.tap_load  = accept;
  assign ctl.tap_shift = (state_r == ST_SCAN);

  mdd_chain u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .ins_val  (in_sample),
    .count    (cnt_eff),
    .tap_head (tap_head)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    prev_nxt      = prev_r;
    thr_nxt       = cfg_wr_en ? cfg_wr_data : thr_r;
    trig_nxt      = trig_r;
    drop_nxt      = drop_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_med_nxt   = out_med_r;
    out_trig_nxt  = out_trig_r;
    out_drop_nxt  = out_drop_r;
    out_full_nxt  = out_full_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          drop_nxt  = drop_clr;
          if (cnt_eff != '0) begin
            if (diff > thr_r && !drop_clr) begin
              if (in_sample < prev_r) begin
                trig_nxt = 1'b1;
              end
            end else begin
              if (trig_r) begin
                drop_nxt = 1'b1;
              end
              trig_nxt = 1'b0;
            end
          end
          count_nxt = cnt_new;
          full_nxt  = is_full;
          scan_nxt  = med_idx;
          state_nxt = (med_idx == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_nxt = scan_r - 1'b1;
        if (scan_r == mdd_pkg::idx_t'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          prev_nxt      = tap_head;
          out_valid_nxt = 1'b1;
          out_med_nxt   = tap_head;
          out_trig_nxt  = trig_r;
          out_drop_nxt  = drop_r;
          out_full_nxt  = full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      prev_r      <= '0;
      thr_r       <= mdd_pkg::THR_RESET;
      trig_r      <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      prev_r      <= prev_nxt;
      thr_r       <= thr_nxt;
      trig_r      <= trig_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r     <= scan_nxt;
    full_r     <= full_nxt;
    out_med_r  <= out_med_nxt;
    out_trig_r <= out_trig_nxt;
    out_drop_r <= out_drop_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_window_median = out_med_r;
  assign out_trigger_armed = out_trig_r;
  assign out_drop_detected = out_drop_r;
  assign out_window_full   = out_full_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mdd_pkg::cnt_t'(mdd_pkg::WINDOW_DEPTH))
    else $error("window count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_restart && count_r < mdd_pkg::cnt_t'(mdd_pkg::WINDOW_DEPTH))
    |=> count_r == $past(count_r) + 1'b1)
    else $error("count not advanced on insert");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside final cycle");

  a_scan_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> (state_r == ST_DONE) || (scan_r == $past(scan_r) - 1'b1))
    else $error("read-out scan stalled");
`endif

endmodule
